// ===== hdl/scr_pkg.sv =====
// shared types, constants and arithmetic helpers for the stereo comb/allpass reverb
`timescale 1ns / 1ps
package scr_pkg;

  localparam int PREDELAY_LEN  = 960;
  localparam int COMB_COUNT    = 8;
  localparam int ALLPASS_COUNT = 4;
  localparam int SAMPLE_RATE   = 48000;

  localparam int PD_AW     = $clog2(PREDELAY_LEN);
  localparam int COMB_DEPTH = 42054;
  localparam int COMB_AW    = $clog2(COMB_DEPTH);
  localparam int AP_DEPTH   = 4698;
  localparam int AP_AW      = $clog2(AP_DEPTH);
  localparam int CPTR_W     = 14;
  localparam int APTR_W     = 12;
  localparam int CK_W       = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
  localparam int AK_W       = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [15:0] Q15_MIN = -16'sh8000;
  localparam logic [14:0] Q15_ONE = 15'h7FFF;

  typedef enum logic [CFG_AW-1:0] {
    REG_ENABLE       = 3'd0,
    REG_DRY_GAIN     = 3'd1,
    REG_WET_GAIN     = 3'd2,
    REG_MASTER_GAIN  = 3'd3,
    REG_AP_COEF      = 3'd4,
    REG_DAMPING      = 3'd5
  } reg_idx_t;

  // per side: left first, right second
  localparam logic [CPTR_W-1:0] COMB_LEN [2][8] = '{
    '{14'd509, 14'd863, 14'd1481, 14'd2521, 14'd4273, 14'd7253, 14'd10007, 14'd15013},
    '{14'd523, 14'd877, 14'd1489, 14'd2531, 14'd4283, 14'd7283, 14'd10037, 14'd15031}
  };
  localparam logic [COMB_AW-1:0] COMB_BASE [2][8] = '{
    '{16'd0, 16'd509, 16'd1372, 16'd2853, 16'd5374, 16'd9647, 16'd16900, 16'd26907},
    '{16'd0, 16'd523, 16'd1400, 16'd2889, 16'd5420, 16'd9703, 16'd16986, 16'd27023}
  };
  localparam logic [APTR_W-1:0] AP_LEN [2][4] = '{
    '{12'd142, 12'd396, 12'd1071, 12'd3079},
    '{12'd145, 12'd399, 12'd1073, 12'd3081}
  };
  localparam logic [AP_AW-1:0] AP_BASE [2][4] = '{
    '{13'd0, 13'd142, 13'd538, 13'd1609},
    '{13'd0, 13'd145, 13'd544, 13'd1617}
  };
  localparam logic [14:0] COMB_FB [8] = '{
    15'd24445, 15'd21659, 15'd19232, 15'd20820,
    15'd24094, 15'd27535, 15'd28372, 15'd29412
  };
  localparam logic [14:0] COMB_WEIGHT [8] = '{
    15'd20316, 15'd19660, 15'd19005, 15'd18022,
    15'd17039, 15'd16384, 15'd15728, 15'd14745
  };

  typedef struct packed {
    logic [14:0] dry_gain;
    logic [14:0] wet_gain;
    logic [15:0] master_gain;
    logic [14:0] ap_coef;
    logic [14:0] damping;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_status_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PWAIT, ST_CREAD, ST_CFB, ST_CLP1, ST_CLP2, ST_CWGT,
    ST_AREAD, ST_AY, ST_AW, ST_MIX1, ST_MIX2, ST_MIX3, ST_DONE
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] x);
    logic signed [15:0] r;
    if (x > 36'sd32767) r = Q15_MAX;
    else if (x < -36'sd32768) r = Q15_MIN;
    else r = x[15:0];
    return r;
  endfunction

endpackage

// ===== hdl/scr_lane.sv =====
// one channel lane: pre-delay, comb bank, allpass chain and mix on a shared multiplier
`timescale 1ns / 1ps
module scr_lane
  import scr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                side,
  input  logic                start,
  input  logic                take,
  input  logic signed [15:0]  sample,
  input  cfg_t                cfg,
  output lane_status_t        status,
  output logic signed [15:0]  result
);

  state_t state, state_next;

  logic [CK_W-1:0]   k;
  logic [AK_W-1:0]   j;
  logic [PD_AW-1:0]  pptr;
  logic              pwrap;
  logic [CPTR_W-1:0] cptr [COMB_COUNT];
  logic [COMB_COUNT-1:0] cwrap;
  logic [APTR_W-1:0] aptr [ALLPASS_COUNT];
  logic [ALLPASS_COUNT-1:0] awrap;
  logic signed [15:0] lp [COMB_COUNT];

  logic signed [15:0] dry, pre, d, fbq, t1, x, yv, mix;
  logic signed [19:0] acc;
  logic               dvld;

  logic signed [15:0] pd_mem [PREDELAY_LEN];
  logic signed [15:0] comb_mem [COMB_DEPTH];
  logic signed [15:0] ap_mem [AP_DEPTH];
  logic signed [15:0] pd_rd, c_rd, a_rd;

  logic [COMB_AW-1:0] caddr;
  logic [AP_AW-1:0]   aaddr;
  logic signed [15:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [33:0] prod;
  logic signed [15:0] q;
  logic               pd_we, c_we, a_we;
  logic signed [15:0] c_wd, a_wd, lpn, c_d, a_d;
  logic               last_comb, last_ap;

  assign caddr = COMB_BASE[side][k] + COMB_AW'(cptr[k]);
  assign aaddr = AP_BASE[side][j] + AP_AW'(aptr[j]);
  assign prod  = 34'(mul_a) * signed'({18'd0, mul_b});
  assign q     = sat16(36'(prod >>> 15));
  assign c_d   = dvld ? c_rd : 16'sd0;
  assign a_d   = dvld ? a_rd : 16'sd0;
  assign lpn   = sat16(36'(t1) + 36'(q));
  assign c_wd  = sat16(36'(pre) + 36'(lpn));
  assign a_wd  = sat16(36'(x) + 36'(q));
  assign last_comb = (k == CK_W'(COMB_COUNT - 1));
  assign last_ap   = (j == AK_W'(ALLPASS_COUNT - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_PWAIT;
      ST_PWAIT: state_next = ST_CREAD;
      ST_CREAD: state_next = ST_CFB;
      ST_CFB:   state_next = ST_CLP1;
      ST_CLP1:  state_next = ST_CLP2;
      ST_CLP2:  state_next = ST_CWGT;
      ST_CWGT:  state_next = last_comb ? ST_AREAD : ST_CREAD;
      ST_AREAD: state_next = ST_AY;
      ST_AY:    state_next = ST_AW;
      ST_AW:    state_next = last_ap ? ST_MIX1 : ST_AREAD;
      ST_MIX1:  state_next = ST_MIX2;
      ST_MIX2:  state_next = ST_MIX3;
      ST_MIX3:  state_next = ST_DONE;
      ST_DONE:  if (take) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // multiplier operands and write strobes
  always_comb begin
    mul_a = 16'sd0;
    mul_b = 16'd0;
    pd_we = 1'b0;
    c_we  = 1'b0;
    a_we  = 1'b0;
    unique case (state)
      ST_IDLE:  pd_we = start;
      ST_CFB:   begin mul_a = c_d;   mul_b = {1'b0, COMB_FB[k]}; end
      ST_CLP1:  begin mul_a = lp[k]; mul_b = {1'b0, Q15_ONE - cfg.damping}; end
      ST_CLP2:  begin mul_a = fbq;   mul_b = {1'b0, cfg.damping}; c_we = 1'b1; end
      ST_CWGT:  begin mul_a = d;     mul_b = {1'b0, COMB_WEIGHT[k]}; end
      ST_AY:    begin mul_a = x;     mul_b = {1'b0, cfg.ap_coef}; end
      ST_AW:    begin mul_a = yv;    mul_b = {1'b0, cfg.ap_coef}; a_we = 1'b1; end
      ST_MIX1:  begin mul_a = dry;   mul_b = {1'b0, cfg.dry_gain}; end
      ST_MIX2:  begin mul_a = x;     mul_b = {1'b0, cfg.wet_gain}; end
      ST_MIX3:  begin mul_a = mix;   mul_b = cfg.master_gain; end
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // delay memories, read data registered, read before write
  always_ff @(posedge clk) begin
    pd_rd <= pd_mem[pptr];
    if (pd_we) pd_mem[pptr] <= sample;
  end
  always_ff @(posedge clk) begin
    c_rd <= comb_mem[caddr];
    if (c_we) comb_mem[caddr] <= c_wd;
  end
  always_ff @(posedge clk) begin
    a_rd <= ap_mem[aaddr];
    if (a_we) ap_mem[aaddr] <= a_wd;
  end

  // pointers, first-pass flags and lowpass states; an entry not yet written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pptr  <= '0;
      pwrap <= 1'b0;
      cwrap <= '0;
      awrap <= '0;
      for (int i = 0; i < COMB_COUNT; i++) begin
        cptr[i] <= '0;
        lp[i]   <= 16'sd0;
      end
      for (int i = 0; i < ALLPASS_COUNT; i++) aptr[i] <= '0;
    end else begin
      if (pd_we) begin
        if (pptr == PD_AW'(PREDELAY_LEN - 1)) begin
          pptr  <= '0;
          pwrap <= 1'b1;
        end else begin
          pptr <= pptr + 1'b1;
        end
      end
      if (c_we) begin
        lp[k] <= lpn;
        if (cptr[k] == COMB_LEN[side][k] - 1'b1) begin
          cptr[k]  <= '0;
          cwrap[k] <= 1'b1;
        end else begin
          cptr[k] <= cptr[k] + 1'b1;
        end
      end
      if (a_we) begin
        if (aptr[j] == AP_LEN[side][j] - 1'b1) begin
          aptr[j]  <= '0;
          awrap[j] <= 1'b1;
        end else begin
          aptr[j] <= aptr[j] + 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (start) begin
        dry  <= sample;
        dvld <= pwrap;
        k    <= '0;
        j    <= '0;
        acc  <= 20'sd0;
      end
      ST_PWAIT: pre <= dvld ? pd_rd : 16'sd0;
      ST_CREAD: dvld <= cwrap[k];
      ST_CFB: begin
        d   <= c_d;
        fbq <= q;
      end
      ST_CLP1: t1 <= q;
      ST_CWGT: begin
        acc <= acc + 20'(q);
        if (last_comb) x <= sat16(36'(acc) + 36'(q));
        else k <= k + 1'b1;
      end
      ST_AREAD: dvld <= awrap[j];
      ST_AY: yv <= sat16(36'(a_d) - 36'(q));
      ST_AW: begin
        x <= yv;
        if (!last_ap) j <= j + 1'b1;
      end
      ST_MIX1: t1 <= q;
      ST_MIX2: mix <= sat16(36'(t1) + 36'(q));
      ST_MIX3: result <= q;
      default: ;
    endcase
  end

  assign status.idle = (state == ST_IDLE);
  assign status.done = (state == ST_DONE);

endmodule

// ===== hdl/stereo_q15_comb_allpass_reverb.sv =====
// top level: stream ports, configuration registers, two channel lanes and output merge
`timescale 1ns / 1ps
//
//  channel   | direction | contents
//  s_axis    | in        | tdata[31:0] left_in, tdata[63:32] right_in
//  m_axis    | out       | tdata[31:0] left_out, tdata[63:32] right_out
//  cfg       | in        | cfg_we, cfg_addr (register index), cfg_data
//
//  an enabled frame runs from transfer in to result ready through the single shared
//  multiplier in each lane, which steps through 8 combs and 4 allpasses
//  both lanes run side by side in lock step; a bypassed frame lands in the output register
//  the next frame is taken once the lanes have handed their result on
//  rst is synchronous; delay lines need no clearing pass, first-pass flags mask old data
//  a stalled output holds its register and the lanes wait in their done state
module stereo_q15_comb_allpass_reverb
  import scr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // left_in [31:0], right_in [63:32]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [63:0]       m_axis_tdata,   // left_out [31:0], right_out [63:32]
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  logic         enable;
  cfg_t         cfg;
  lane_status_t st_l, st_r;
  logic signed [15:0] res_l, res_r;
  logic         in_xfer, start, take, out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable           <= 1'b1;
      cfg.dry_gain     <= 15'd16384;
      cfg.wet_gain     <= 15'd16384;
      cfg.master_gain  <= 16'd49151;
      cfg.ap_coef      <= 15'd16384;
      cfg.damping      <= 15'd13107;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ENABLE:       enable           <= cfg_data[0];
        REG_DRY_GAIN:     cfg.dry_gain     <= cfg_data[14:0];
        REG_WET_GAIN:     cfg.wet_gain     <= cfg_data[14:0];
        REG_MASTER_GAIN:  cfg.master_gain  <= cfg_data;
        REG_AP_COEF:      cfg.ap_coef      <= cfg_data[14:0];
        REG_DAMPING:      cfg.damping      <= cfg_data[14:0];
        default:          ;
      endcase
    end
  end

  // output slot free this cycle
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  // bypass frames need the slot, reverb frames only need idle lanes
  assign s_axis_tready = st_l.idle && st_r.idle && (enable || out_free);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign start         = in_xfer && enable;
  assign take          = st_l.done && st_r.done && out_free;

  scr_lane u_lane_l (
    .clk    (clk),
    .rst    (rst),
    .side   (1'b0),
    .start  (start),
    .take   (take),
    .sample (s_axis_tdata[31:16]),
    .cfg    (cfg),
    .status (st_l),
    .result (res_l)
  );

  scr_lane u_lane_r (
    .clk    (clk),
    .rst    (rst),
    .side   (1'b1),
    .start  (start),
    .take   (take),
    .sample (s_axis_tdata[63:48]),
    .cfg    (cfg),
    .status (st_r),
    .result (res_r)
  );

  // merge: lane results (q15 in each sample's top half) or a bypassed frame into the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (in_xfer && !enable) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) m_axis_tdata <= {res_r, 16'h0000, res_l, 16'h0000};
    else if (in_xfer && !enable) m_axis_tdata <= s_axis_tdata;
  end

endmodule

// ===== tb/sv/stereo_q15_comb_allpass_reverb_tb.sv =====
// self-checking testbench for the stereo comb/allpass reverb
`timescale 1ns / 1ps
module stereo_q15_comb_allpass_reverb_tb;
  import scr_pkg::*;

  typedef struct packed {
    logic [31:0] right;
    logic [31:0] left;
  } frame_t;

  // length tables, kept here so the predictor is independent of the block
  localparam int LEN_CL [8] = '{509, 863, 1481, 2521, 4273, 7253, 10007, 15013};
  localparam int LEN_CR [8] = '{523, 877, 1489, 2531, 4283, 7283, 10037, 15031};
  localparam int LEN_AL [4] = '{142, 396, 1071, 3079};
  localparam int LEN_AR [4] = '{145, 399, 1073, 3081};
  localparam int FB_TAB [8] = '{24445, 21659, 19232, 20820, 24094, 27535, 28372, 29412};
  localparam int WT_TAB [8] = '{20316, 19660, 19005, 18022, 17039, 16384, 15728, 14745};
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // left_in [31:0], right_in [63:32]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // left_out [31:0], right_out [63:32]
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  stereo_q15_comb_allpass_reverb u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  int unsigned r_en, r_dry, r_wet, r_master, r_ap, r_damp;
  shortint pd_l [PREDELAY_LEN];
  shortint pd_r [PREDELAY_LEN];
  int pd_ptr;
  shortint comb_l [8][];
  shortint comb_r [8][];
  shortint ap_l [4][];
  shortint ap_r [4][];
  int lp_state [2][8];
  int comb_ptr [2][8];
  int ap_ptr [2][4];

  frame_t pending_frames [$];
  frame_t expected_frames [$];
  int errors = 0;
  int cycles = 0;
  bit long_hold = 0;

  function automatic int sat16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return int'(x);
  endfunction

  // q15 multiply, floored then saturated (>>> on signed floors)
  function automatic int qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat16(p >>> 15);
  endfunction

  function automatic void clear_reverb_state();
    for (int i = 0; i < PREDELAY_LEN; i++) begin
      pd_l[i] = 0;
      pd_r[i] = 0;
    end
    pd_ptr = 0;
    for (int k = 0; k < 8; k++) begin
      comb_l[k] = new[LEN_CL[k]];
      comb_r[k] = new[LEN_CR[k]];
      foreach (comb_l[k][i]) comb_l[k][i] = 0;
      foreach (comb_r[k][i]) comb_r[k][i] = 0;
      lp_state[0][k] = 0; lp_state[1][k] = 0;
      comb_ptr[0][k] = 0; comb_ptr[1][k] = 0;
    end
    for (int k = 0; k < 4; k++) begin
      ap_l[k] = new[LEN_AL[k]];
      ap_r[k] = new[LEN_AR[k]];
      foreach (ap_l[k][i]) ap_l[k][i] = 0;
      foreach (ap_r[k][i]) ap_r[k][i] = 0;
      ap_ptr[0][k] = 0; ap_ptr[1][k] = 0;
    end
    r_en = 1; r_dry = 16384; r_wet = 16384;
    r_master = 49151; r_ap = 16384; r_damp = 13107;
  endfunction

  function automatic int reverb_channel(int pre, int dry, int side);
    longint sum;
    int d, fbq, wet, y, p, len;
    sum = 0;
    for (int k = 0; k < 8; k++) begin
      p = comb_ptr[side][k];
      len = side ? LEN_CR[k] : LEN_CL[k];
      d = side ? comb_r[k][p] : comb_l[k][p];
      fbq = qmul(FB_TAB[k], d);
      lp_state[side][k] = sat16(longint'(qmul(lp_state[side][k], 32767 - int'(r_damp)))
                                + qmul(fbq, int'(r_damp)));
      if (side) comb_r[k][p] = shortint'(sat16(longint'(pre) + lp_state[side][k]));
      else comb_l[k][p] = shortint'(sat16(longint'(pre) + lp_state[side][k]));
      comb_ptr[side][k] = (p + 1 >= len) ? 0 : p + 1;
      sum += qmul(d, WT_TAB[k]);
    end
    wet = sat16(sum);
    for (int k = 0; k < 4; k++) begin
      p = ap_ptr[side][k];
      len = side ? LEN_AR[k] : LEN_AL[k];
      d = side ? ap_r[k][p] : ap_l[k][p];
      y = sat16(longint'(d) - qmul(wet, int'(r_ap)));
      if (side) ap_r[k][p] = shortint'(sat16(longint'(wet) + qmul(y, int'(r_ap))));
      else ap_l[k][p] = shortint'(sat16(longint'(wet) + qmul(y, int'(r_ap))));
      ap_ptr[side][k] = (p + 1 >= len) ? 0 : p + 1;
      wet = y;
    end
    return qmul(sat16(longint'(qmul(dry, int'(r_dry))) + qmul(wet, int'(r_wet))),
                int'(r_master));
  endfunction

  function automatic frame_t predict_reverb(frame_t f);
    frame_t r;
    int dl, dr, pl, pr;
    logic [15:0] yl, yr;
    if (r_en == 0) return f;
    dl = int'($signed(f.left[31:16]));
    dr = int'($signed(f.right[31:16]));
    pl = pd_l[pd_ptr];
    pr = pd_r[pd_ptr];
    pd_l[pd_ptr] = shortint'(dl);
    pd_r[pd_ptr] = shortint'(dr);
    pd_ptr = (pd_ptr + 1 >= PREDELAY_LEN) ? 0 : pd_ptr + 1;
    yl = 16'(reverb_channel(pl, dl, 0));
    yr = 16'(reverb_channel(pr, dr, 1));
    r.left = {yl, 16'h0000};
    r.right = {yr, 16'h0000};
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %08h want %08h", what, got, want);
    errors++;
  endtask

  // driver: bursts and gaps, prediction at each accepted transfer
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    frame_t f;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        f = pending_frames.pop_front();
        expected_frames.push_back(predict_reverb(f));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (s_axis_tvalid && !s_axis_tready) begin
        // keep the offered item steady until it transfers
      end else if (pending_frames.size() > 0) begin
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 150);
          s_axis_tvalid <= 1'b0;
        end else begin
          burst_left <= burst_left - 1;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_frames[0];
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_left = 0;
  always @(posedge clk) begin
    frame_t got, want;
    cycles <= cycles + 1;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_frames.size() == 0) begin
          report_mismatch("unexpected transfer", got.left, 32'h0000_0000);
        end else begin
          want = expected_frames.pop_front();
          if (got.left !== want.left) report_mismatch("left_out", got.left, want.left);
          if (got.right !== want.right) report_mismatch("right_out", got.right, want.right);
        end
      end
      if (long_hold) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 200);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-off, counted here, while the sender keeps offering
  initial begin
    while (rst || pending_frames.size() < 20 || expected_frames.size() == 0)
      @(posedge clk);
    @(negedge clk);
    long_hold = 1;
    repeat (3000) @(posedge clk);
    @(negedge clk);
    long_hold = 0;
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("stereo_q15_comb_allpass_reverb regression: fail");
      $finish;
    end
  end

  task automatic drain_all();
    while (pending_frames.size() != 0 || s_axis_tvalid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLE: r_en = v[0];
      REG_DRY_GAIN: r_dry = v[14:0];
      REG_WET_GAIN: r_wet = v[14:0];
      REG_MASTER_GAIN: r_master = v;
      REG_AP_COEF: r_ap = v[14:0];
      REG_DAMPING: r_damp = v[14:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'($urandom())};
      3: return $urandom() >>> $urandom_range(4, 12);
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_random(int n);
    frame_t f;
    for (int i = 0; i < n; i++) begin
      f.left = rand_sample();
      f.right = rand_sample();
      pending_frames.push_back(f);
    end
  endtask

  initial begin
    frame_t f;
    clear_reverb_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes at reset settings, then a run of full-scale positive frames
    f = '{right: 32'h7FFF_FFFF, left: 32'h8000_0000}; pending_frames.push_back(f);
    f = '{right: 32'h8000_0000, left: 32'h7FFF_FFFF}; pending_frames.push_back(f);
    f = '{right: 32'hFFFF_FFFF, left: 32'h0000_0000}; pending_frames.push_back(f);
    f = '{right: 32'h0001_5555, left: 32'hFFFE_AAAA}; pending_frames.push_back(f);
    for (int i = 0; i < 6; i++) begin
      f = '{right: 32'h7FFF_0000, left: 32'h7FFF_0000}; pending_frames.push_back(f);
    end
    drain_all();
    // bypass passes the frame untouched, low bits included
    write_reg(REG_ENABLE, 16'h0000);
    f = '{right: 32'h1234_5678, left: 32'h9ABC_DEF0}; pending_frames.push_back(f);
    f = '{right: 32'h8000_0001, left: 32'h7FFF_FFFE}; pending_frames.push_back(f);
    drain_all();
    write_reg(REG_ENABLE, 16'hFFFF);
    // maximum gains for saturation
    write_reg(REG_DRY_GAIN, 16'hFFFF);
    write_reg(REG_WET_GAIN, 16'h7FFF);
    write_reg(REG_MASTER_GAIN, 16'hFFFF);
    write_reg(REG_AP_COEF, 16'h7FFF);
    write_reg(REG_DAMPING, 16'h7FFF);
    for (int i = 0; i < 8; i++) begin
      f = '{right: 32'h8000_0000, left: 32'h7FFF_FFFF}; pending_frames.push_back(f);
    end
    drain_all();
    // random phases across settings
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 4) begin
        write_reg(REG_DRY_GAIN, 16'h0000);
        write_reg(REG_WET_GAIN, 16'h0000);
        write_reg(REG_MASTER_GAIN, 16'h0000);
        write_reg(REG_AP_COEF, 16'h0000);
        write_reg(REG_DAMPING, 16'h0000);
      end else if (ph == 6) begin
        write_reg(REG_ENABLE, 16'h0000);
      end else if (ph == 7) begin
        write_reg(REG_ENABLE, 16'h0001);
      end else if (ph > 0) begin
        write_reg(REG_DRY_GAIN, 16'($urandom()));
        write_reg(REG_WET_GAIN, 16'($urandom()));
        write_reg(REG_MASTER_GAIN, 16'($urandom()));
        write_reg(REG_AP_COEF, 16'($urandom()));
        write_reg(REG_DAMPING, 16'($urandom()));
      end
      queue_random(125);
      drain_all();
    end
    if (errors == 0) begin
      $display("stereo_q15_comb_allpass_reverb regression: pass");
    end else begin
      $display("stereo_q15_comb_allpass_reverb regression: fail");
    end
    $finish;
  end

endmodule

// ===== stereo_q15_comb_allpass_reverb.f =====
hdl/scr_pkg.sv
hdl/scr_lane.sv
hdl/stereo_q15_comb_allpass_reverb.sv
tb/sv/stereo_q15_comb_allpass_reverb_tb.sv
